// ===== sv/preamble_crc16_frame_parser_unit_macros.svh =====
// assertion macros for the preamble crc16 frame parser checker
`ifndef PREAMBLE_CRC16_FRAME_PARSER_UNIT_MACROS_SVH
`define PREAMBLE_CRC16_FRAME_PARSER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define PCFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcfp assertion failed");

// next-cycle implication, disabled in reset
`define PCFP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcfp assertion failed");

`endif

// ===== sv/pcfp_pkg.sv =====
// package: types and constants of the preamble crc16 frame parser
package pcfp_pkg;

    localparam logic [31:0] PREAMBLE_RESET = 32'hCFEB0181;
    localparam logic [15:0] CRC_POLY       = 16'h5935;
    localparam logic [2:0]  HEADER_LAST    = 3'd6;

    localparam logic [2:0] ST_MISMATCH   = 3'd0;
    localparam logic [2:0] ST_PARTIAL    = 3'd1;
    localparam logic [2:0] ST_IN_FRAME   = 3'd2;
    localparam logic [2:0] ST_CRC_ERROR  = 3'd3;
    localparam logic [2:0] ST_FRAME_GOOD = 3'd4;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_HEADER,
        PH_PAYLOAD,
        PH_CRC
    } phase_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic [7:0]  frame_address;
        logic [15:0] local_port;
        logic [15:0] remote_port;
        logic [9:0]  payload_length;
    } result_t;

endpackage

// ===== sv/pcfp_ifs.sv =====
// channel interfaces: received bytes, parse results, preamble register writes
interface pcfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface pcfp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic [7:0]  frame_address;
    logic [15:0] local_port;
    logic [15:0] remote_port;
    logic [9:0]  payload_length;

    modport source (
        output valid, output status, output payload_byte, output payload_valid,
        output frame_address, output local_port, output remote_port,
        output payload_length, input ready
    );
    modport sink (
        input valid, input status, input payload_byte, input payload_valid,
        input frame_address, input local_port, input remote_port,
        input payload_length, output ready
    );
endinterface

interface pcfp_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] preamble_word;

    modport source (output valid, output preamble_word, input ready);
    modport sink (input valid, input preamble_word, output ready);
endinterface

// ===== sv/pcfp_in_stage.sv =====
// input register: holds one received byte until the parser takes it
module pcfp_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       held_valid,
    output logic [7:0] held_byte,
    input  logic       take
);
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign in_ready   = !valid_reg || take;
    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
        end
    end
endmodule

// ===== sv/pcfp_crc_byte.sv =====
// crc16 update over one byte, msb first
module pcfp_crc_byte (
    input  logic [15:0] crc_in,
    input  logic [7:0]  data,
    output logic [15:0] crc_out
);
    import pcfp_pkg::*;

    always_comb
    begin
        logic [15:0] cur;
        logic        fb;
        cur = crc_in;
        for (int i = 7; i >= 0; i--)
        begin
            fb  = cur[15] ^ data[i];
            cur = {cur[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        crc_out = cur;
    end
endmodule

// ===== sv/pcfp_parser.sv =====
// frame parser: preamble hunt, header capture, payload pass-through, crc check
module pcfp_parser #(
    parameter int MAX_PAYLOAD = 512
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_data,
    input  logic                take,
    input  logic [7:0]          rx_byte,
    output pcfp_pkg::result_t   result
);
    import pcfp_pkg::*;

    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
    localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

    logic [31:0]      preamble_reg;
    phase_t           phase_reg, phase_next;
    logic [1:0]       pidx_reg, pidx_next;
    logic [2:0]       hcount_reg, hcount_next;
    logic             crc_lo_seen_reg, crc_lo_seen_next;
    logic [LEN_W-1:0] clip_reg, clip_next;
    logic [LEN_W-1:0] pcount_reg, pcount_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       crc_lo_reg, crc_lo_next;
    logic [55:0]      hdr_reg, hdr_next;

    logic [15:0]      crc_upd;
    logic [7:0]       expect_byte;
    logic [15:0]      len_raw;
    logic [LEN_W+9:0] clip_ext;

    pcfp_crc_byte u_crc (
        .crc_in  (crc_reg),
        .data    (rx_byte),
        .crc_out (crc_upd)
    );

    assign expect_byte = preamble_reg[{~pidx_reg, 3'b000} +: 8];
    assign len_raw     = hdr_reg[15:0];
    assign clip_ext    = {10'd0, clip_reg};

    always_comb
    begin
        phase_next       = phase_reg;
        pidx_next        = pidx_reg;
        hcount_next      = hcount_reg;
        crc_lo_seen_next = crc_lo_seen_reg;
        clip_next        = clip_reg;
        pcount_next      = pcount_reg;
        crc_next         = crc_reg;
        crc_lo_next      = crc_lo_reg;
        hdr_next         = hdr_reg;
        result           = '0;

        case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte != expect_byte)
                begin
                    pidx_next     = 2'd0;
                    result.status = ST_MISMATCH;
                end
                else if (pidx_reg == 2'd3)
                begin
                    pidx_next     = 2'd0;
                    phase_next    = PH_HEADER;
                    hcount_next   = 3'd0;
                    hdr_next      = '0;
                    crc_next      = '0;
                    result.status = ST_IN_FRAME;
                end
                else
                begin
                    pidx_next     = pidx_reg + 2'd1;
                    result.status = ST_PARTIAL;
                end
            end
            PH_HEADER:
            begin
                crc_next = crc_upd;
                hdr_next[{hcount_reg, 3'b000} +: 8] = rx_byte;
                hcount_next = hcount_reg + 3'd1;
                if (hcount_reg == HEADER_LAST)
                begin
                    // length bytes are already in place by the last header byte
                    clip_next   = (len_raw < MAX_LEN) ? LEN_W'(len_raw)
                                                      : LEN_W'(MAX_PAYLOAD);
                    pcount_next = '0;
                    hcount_next = 3'd0;
                    crc_lo_seen_next = 1'b0;
                    phase_next  = (clip_next != '0) ? PH_PAYLOAD : PH_CRC;
                end
                result.status = ST_IN_FRAME;
            end
            PH_PAYLOAD:
            begin
                crc_next             = crc_upd;
                result.payload_byte  = rx_byte;
                result.payload_valid = 1'b1;
                pcount_next          = pcount_reg + LEN_W'(1);
                if (pcount_next == clip_reg)
                begin
                    crc_lo_seen_next = 1'b0;
                    phase_next       = PH_CRC;
                end
                result.status = ST_IN_FRAME;
            end
            PH_CRC:
            begin
                if (!crc_lo_seen_reg)
                begin
                    crc_lo_next      = rx_byte;
                    crc_lo_seen_next = 1'b1;
                    result.status    = ST_IN_FRAME;
                end
                else
                begin
                    result.status = ({rx_byte, crc_lo_reg} == crc_reg) ? ST_FRAME_GOOD
                                                                        : ST_CRC_ERROR;
                    result.frame_address  = hdr_reg[23:16];
                    result.local_port     = hdr_reg[39:24];
                    result.remote_port    = hdr_reg[55:40];
                    result.payload_length = clip_ext[9:0];
                    crc_lo_seen_next      = 1'b0;
                    phase_next            = PH_HUNT;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preamble_reg    <= PREAMBLE_RESET;
            phase_reg       <= PH_HUNT;
            pidx_reg        <= 2'd0;
            hcount_reg      <= 3'd0;
            crc_lo_seen_reg <= 1'b0;
            clip_reg        <= '0;
            pcount_reg      <= '0;
            crc_reg         <= '0;
            crc_lo_reg      <= '0;
            hdr_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                preamble_reg <= cfg_data;
            end
            if (take)
            begin
                phase_reg       <= phase_next;
                pidx_reg        <= pidx_next;
                hcount_reg      <= hcount_next;
                crc_lo_seen_reg <= crc_lo_seen_next;
                clip_reg        <= clip_next;
                pcount_reg      <= pcount_next;
                crc_reg         <= crc_next;
                crc_lo_reg      <= crc_lo_next;
                hdr_reg         <= hdr_next;
            end
        end
    end
endmodule

// ===== sv/pcfp_out_stage.sv =====
// result register: holds one parse result until the consumer takes it
module pcfp_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  pcfp_pkg::result_t load_data,
    output logic              can_load,
    output logic              out_valid,
    input  logic              out_ready,
    output pcfp_pkg::result_t out_data
);
    import pcfp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign can_load  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end
endmodule

// ===== sv/preamble_crc16_frame_parser_unit.sv =====
// top level of the preamble / length / crc16 frame parser
//
//  channel  modport  payload                                     direction
//  rx       sink     rx_byte                                     byte in
//  result   source   status, payload_byte, payload_valid,
//                    frame_address, local_port, remote_port,
//                    payload_length                              one result per byte
//  cfg      sink     preamble_word                               register write
//
// one byte per cycle sustained while the result side is ready; each byte yields one
// result, registered in the input register and then in the result register
// parse state advances only when a byte moves from the input register into the
// result register, so stalls on the result side simply hold both stages
// reset: preamble register to 0xcfeb0181, hunting for the preamble, both stages empty
// cfg is always ready; a write takes effect on the next byte parsed
module preamble_crc16_frame_parser_unit #(
    parameter int MAX_PAYLOAD = 512
) (
    input  logic              clk,
    input  logic              rst_n,
    pcfp_in_if.sink           rx,
    pcfp_out_if.source        result,
    pcfp_cfg_if.sink          cfg
);
    import pcfp_pkg::*;

    // input register side
    logic       held_valid;
    logic [7:0] held_byte;

    // result register side
    logic       can_load;
    logic       take;
    result_t    parsed;
    result_t    out_data;

    // a byte is parsed in the cycle it leaves the input register
    assign take      = held_valid && can_load;
    assign cfg.ready = 1'b1;

    pcfp_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (rx.valid),
        .in_ready   (rx.ready),
        .in_byte    (rx.rx_byte),
        .held_valid (held_valid),
        .held_byte  (held_byte),
        .take       (take)
    );

    pcfp_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg.valid),
        .cfg_data (cfg.preamble_word),
        .take     (take),
        .rx_byte  (held_byte),
        .result   (parsed)
    );

    pcfp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .load_data (parsed),
        .can_load  (can_load),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (out_data)
    );

    // unpack the registered result onto the channel
    assign result.status         = out_data.status;
    assign result.payload_byte   = out_data.payload_byte;
    assign result.payload_valid  = out_data.payload_valid;
    assign result.frame_address  = out_data.frame_address;
    assign result.local_port     = out_data.local_port;
    assign result.remote_port    = out_data.remote_port;
    assign result.payload_length = out_data.payload_length;
endmodule

// ===== sv/pcfp_checker.sv =====
// port-level checker for the frame parser, bound to the top level
`include "preamble_crc16_frame_parser_unit_macros.svh"

module pcfp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [2:0]  status,
    input logic [7:0]  payload_byte,
    input logic        payload_valid,
    input logic [7:0]  frame_address,
    input logic [15:0] local_port,
    input logic [15:0] remote_port,
    input logic [9:0]  payload_length
);
    import pcfp_pkg::*;

    logic frame_end;
    assign frame_end = (status == ST_CRC_ERROR) || (status == ST_FRAME_GOOD);

    // payload bytes only appear inside a frame, and read zero otherwise
    `PCFP_ASSERT_IMP(a_payload_in_frame, clk, rst_n, res_valid && payload_valid, status == ST_IN_FRAME)
    `PCFP_ASSERT_IMP(a_payload_zero, clk, rst_n, res_valid && !payload_valid, payload_byte == 8'd0)

    // header fields are shown only with the end-of-frame verdict
    `PCFP_ASSERT_IMP(a_fields_at_end, clk, rst_n, res_valid && !frame_end, (frame_address == 8'd0) && (local_port == 16'd0) && (remote_port == 16'd0) && (payload_length == 10'd0))

    // a stalled result holds
    `PCFP_ASSERT_NXT(a_result_holds, clk, rst_n, res_valid && !res_ready, res_valid && $stable(status) && $stable(payload_byte))
endmodule

bind preamble_crc16_frame_parser_unit pcfp_checker u_pcfp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .status         (result.status),
    .payload_byte   (result.payload_byte),
    .payload_valid  (result.payload_valid),
    .frame_address  (result.frame_address),
    .local_port     (result.local_port),
    .remote_port    (result.remote_port),
    .payload_length (result.payload_length)
);

// ===== dv/tb_preamble_crc16_frame_parser_unit.sv =====
// self-checking testbench of the preamble / length / crc16 frame parser
module tb_preamble_crc16_frame_parser_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import pcfp_pkg::*;

    localparam int MAX_PAYLOAD    = 512;
    localparam int IDLE_PCT       = 32;
    localparam int DRAIN_CYCLES   = 6;      // two-stage pipe plus margin
    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no transaction at all
    localparam int WHOLE_FRAME    = 1 << 30;
    localparam int RANDOM_ITEMS   = 120;    // bytes per random traffic run

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    pcfp_in_if  rx_ch ();
    pcfp_out_if res_ch ();
    pcfp_cfg_if cfg_ch ();

    preamble_crc16_frame_parser_unit #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // parser shadow: register copy and parse state, advanced once per accepted byte
    logic [31:0] pre_word;
    logic [1:0]  match_idx;
    phase_t      ph;
    logic [2:0]  hdr_cnt;
    logic [9:0]  clip_len;
    logic [9:0]  pay_cnt;
    logic [15:0] crc_acc;
    logic [7:0]  crc_lo;
    logic [55:0] hdr_bytes;

    result_t     expected_q[$];     // results owed by the block, oldest first
    int          error_count  = 0;
    int          items_sent   = 0;
    int          stall_cycles = 0;
    bit          no_gaps      = 1'b0;   // suppresses idling on both sides

    // msb-first crc16 step, one byte
    function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    // advance the shadow parser by one byte and return the result it owes
    function automatic result_t parse_byte(input logic [7:0] b);
        result_t     r;
        logic [15:0] len;
        r        = '0;
        r.status = ST_IN_FRAME;
        case (ph)
            PH_HUNT:
            begin
                // a mismatch drops the index without rechecking the byte as a first byte
                if (b !== pre_word[(3 - int'(match_idx)) * 8 +: 8])
                begin
                    match_idx = 2'd0;
                    r.status  = ST_MISMATCH;
                end
                else if (match_idx == 2'd3)
                begin
                    match_idx = 2'd0;
                    ph        = PH_HEADER;
                    hdr_cnt   = 3'd0;
                    hdr_bytes = '0;
                    crc_acc   = '0;
                end
                else
                begin
                    match_idx = match_idx + 2'd1;
                    r.status  = ST_PARTIAL;
                end
            end
            PH_HEADER:
            begin
                crc_acc = crc16_next(crc_acc, b);
                hdr_bytes[hdr_cnt * 8 +: 8] = b;
                hdr_cnt = hdr_cnt + 3'd1;
                if (hdr_cnt == 3'd7)
                begin
                    len      = hdr_bytes[15:0];
                    clip_len = (len < MAX_PAYLOAD) ? len[9:0] : 10'(MAX_PAYLOAD);
                    pay_cnt  = '0;
                    hdr_cnt  = 3'd0;
                    // zero length skips the payload
                    ph       = (clip_len != 10'd0) ? PH_PAYLOAD : PH_CRC;
                end
            end
            PH_PAYLOAD:
            begin
                crc_acc         = crc16_next(crc_acc, b);
                r.payload_byte  = b;
                r.payload_valid = 1'b1;
                pay_cnt         = pay_cnt + 10'd1;
                if (pay_cnt >= clip_len)
                begin
                    hdr_cnt = 3'd0;
                    ph      = PH_CRC;
                end
            end
            PH_CRC:
            begin
                if (hdr_cnt == 3'd0)
                begin
                    crc_lo  = b;
                    hdr_cnt = 3'd1;
                end
                else
                begin
                    r.status         = ({b, crc_lo} == crc_acc) ? ST_FRAME_GOOD : ST_CRC_ERROR;
                    r.frame_address  = hdr_bytes[23:16];
                    r.local_port     = hdr_bytes[39:24];
                    r.remote_port    = hdr_bytes[55:40];
                    r.payload_length = clip_len;
                    hdr_cnt          = 3'd0;
                    ph               = PH_HUNT;
                end
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    // result side: random back-pressure, changed at the falling edge
    always @(negedge clk)
        res_ch.ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);

    // every result transaction is compared with the oldest owed result
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result transaction with no byte outstanding, status %0d",
                       res_ch.status);
                error_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                check_field("status", 16'(want.status), 16'(res_ch.status));
                check_field("payload_byte", 16'(want.payload_byte),
                            16'(res_ch.payload_byte));
                check_field("payload_valid", 16'(want.payload_valid),
                            16'(res_ch.payload_valid));
                check_field("frame_address", 16'(want.frame_address),
                            16'(res_ch.frame_address));
                check_field("local_port", want.local_port, res_ch.local_port);
                check_field("remote_port", want.remote_port, res_ch.remote_port);
                check_field("payload_length", 16'(want.payload_length),
                            16'(res_ch.payload_length));
            end
        end
    end

    // watchdog: any transaction on any channel restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // one byte transaction; valid is left high so back-to-back bytes need no gap
    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while (!no_gaps && $urandom_range(99) < IDLE_PCT)
        begin
            rx_ch.valid <= 1'b0;
            @(negedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        expected_q.push_back(parse_byte(b));
        items_sent++;
    endtask

    // hold the byte stream until every owed result is back
    task automatic drain();
        @(negedge clk);
        rx_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // preamble register write, only with the pipe empty
    task automatic write_preamble(input logic [31:0] w);
        drain();
        @(negedge clk);
        cfg_ch.valid         <= 1'b1;
        cfg_ch.preamble_word <= w;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        pre_word = w;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // feed junk until the parser is hunting with nothing matched
    task automatic resync();
        while (ph != PH_HUNT || match_idx != 2'd0)
        begin
            if (ph == PH_HUNT)
                send_byte(~pre_word[(3 - int'(match_idx)) * 8 +: 8]);
            else
                send_byte(8'($urandom));
        end
    endtask

    // builds a frame for the current preamble and sends bytes first .. cut-1 of it
    task automatic send_frame(input logic [15:0] len, input logic [7:0] addr,
                              input logic [15:0] lport, input logic [15:0] rport,
                              input bit bad_crc, input int first, input int cut);
        logic [7:0]  frame_bytes[$];
        logic [15:0] crc;
        logic [7:0]  pb;
        int          n_pay;
        n_pay = (len < MAX_PAYLOAD) ? int'(len) : MAX_PAYLOAD;
        for (int i = 3; i >= 0; i--)
            frame_bytes.push_back(pre_word[i * 8 +: 8]);
        frame_bytes.push_back(len[7:0]);
        frame_bytes.push_back(len[15:8]);
        frame_bytes.push_back(addr);
        frame_bytes.push_back(lport[7:0]);
        frame_bytes.push_back(lport[15:8]);
        frame_bytes.push_back(rport[7:0]);
        frame_bytes.push_back(rport[15:8]);
        crc = '0;
        for (int i = 4; i < 11; i++)
            crc = crc16_next(crc, frame_bytes[i]);
        repeat (n_pay)
        begin
            pb = 8'($urandom);
            frame_bytes.push_back(pb);
            crc = crc16_next(crc, pb);
        end
        if (bad_crc)
            crc = crc ^ 16'($urandom_range(65535, 1));
        frame_bytes.push_back(crc[7:0]);
        frame_bytes.push_back(crc[15:8]);
        for (int i = first; i < frame_bytes.size() && i < cut; i++)
            send_byte(frame_bytes[i]);
    endtask

    // mostly short payloads, now and then a longer one
    function automatic logic [15:0] pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return 16'd0;
        if (r < 75)
            return 16'($urandom_range(8, 1));
        if (r < 95)
            return 16'($urandom_range(40, 9));
        return 16'($urandom_range(120, 41));
    endfunction

    task automatic do_reset();
        rst_n                = 1'b0;
        rx_ch.valid          = 1'b0;
        rx_ch.rx_byte        = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.preamble_word = '0;
        pre_word             = PREAMBLE_RESET;
        match_idx            = 2'd0;
        ph                   = PH_HUNT;
        hdr_cnt              = '0;
        clip_len             = '0;
        pay_cnt              = '0;
        crc_acc              = '0;
        crc_lo               = '0;
        hdr_bytes            = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    endtask

    // hunting with the reset preamble: noise, a mismatch mid-preamble whose byte
    // is not retried as a first byte, and a mismatch on the last preamble byte
    task automatic test_preamble_hunt();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(pre_word[31:24]);
        send_byte(pre_word[31:24]);
        send_byte(pre_word[31:24]);
        send_byte(pre_word[23:16]);
        send_byte(pre_word[15:8]);
        send_byte(~pre_word[7:0]);
    endtask

    // zero-length frame straight from header to crc, port extremes
    task automatic test_zero_length();
        resync();
        send_frame(16'd0, 8'hFF, 16'h0000, 16'hFFFF, 1'b0, 0, WHOLE_FRAME);
    endtask

    // register rewritten with half a preamble matched: the new word counts from the next byte
    task automatic test_config_mid_preamble();
        resync();
        send_byte(pre_word[31:24]);
        send_byte(pre_word[23:16]);
        write_preamble(32'h5AA5_C33C);
        send_frame(16'd3, 8'h00, 16'hFFFF, 16'h0000, 1'b0, 2, WHOLE_FRAME);
    endtask

    // length field above the limit: clipped payload with a crc over the clipped bytes,
    // then random bytes back in the hunt
    task automatic test_clipped_length();
        resync();
        send_frame(16'hFFFF, 8'h5A, 16'($urandom), 16'($urandom), 1'b0, 0, WHOLE_FRAME);
        repeat (20) send_byte(8'($urandom));
    endtask

    // random traffic under one preamble setting: good frames, crc errors,
    // cut-off frames and line noise
    task automatic test_random_frames(input logic [31:0] w, input int n_items, input bit quiet);
        int start;
        int pick;
        write_preamble(w);
        no_gaps = quiet;
        start   = items_sent;
        while (items_sent - start < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
            begin
                resync();
                send_frame(pick_length(), 8'($urandom), 16'($urandom), 16'($urandom),
                           1'b0, 0, WHOLE_FRAME);
            end
            else if (pick < 78)
            begin
                resync();
                send_frame(pick_length(), 8'($urandom), 16'($urandom), 16'($urandom),
                           1'b1, 0, WHOLE_FRAME);
            end
            else if (pick < 90)
            begin
                resync();
                send_frame(pick_length(), 8'($urandom), 16'($urandom), 16'($urandom),
                           1'b0, 0, $urandom_range(12, 1));
            end
            else
                repeat ($urandom_range(6, 1)) send_byte(8'($urandom));
        end
        drain();
        no_gaps = 1'b0;
    endtask

    initial
    begin
        do_reset();
        test_preamble_hunt();
        test_zero_length();
        test_config_mid_preamble();
        test_clipped_length();
        // register extremes, random words, back to the reset word; one run with no idling
        test_random_frames(32'hFFFF_FFFF, RANDOM_ITEMS, 1'b0);
        test_random_frames(32'h0000_0000, RANDOM_ITEMS, 1'b0);
        test_random_frames($urandom, RANDOM_ITEMS, 1'b1);
        test_random_frames($urandom, RANDOM_ITEMS, 1'b0);
        test_random_frames(PREAMBLE_RESET, RANDOM_ITEMS, 1'b0);
        drain();
        if (expected_q.size() != 0)
        begin
            $error("%0d results never arrived", expected_q.size());
            error_count++;
        end
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/pcfp_pkg.sv
sv/pcfp_ifs.sv
sv/pcfp_in_stage.sv
sv/pcfp_crc_byte.sv
sv/pcfp_parser.sv
sv/pcfp_out_stage.sv
sv/preamble_crc16_frame_parser_unit.sv
sv/pcfp_checker.sv
dv/tb_preamble_crc16_frame_parser_unit.sv
